FILE: rtl/dmst_pkg.sv
// ----------------------------------------------------------------------------
// dmst_pkg
// Types and message codes shared by the DSP message state tracker.
// ----------------------------------------------------------------------------
package dmst_pkg;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] setting_byte;
        logic [7:0] index_byte_six;
        logic [7:0] index_byte_seven;
    } t_in;

    typedef struct packed {
        logic       result_kind;
        logic [4:0] message_kind;
        logic [7:0] first_index;
        logic [7:0] second_index;
        logic [7:0] new_setting;
    } t_out;

    // Decoded beat handed from the sequencer to the cache stage
    typedef struct packed {
        logic       is_cache;
        logic       is_meter;
        logic [4:0] msg;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] value;
    } t_req;

    localparam logic [4:0] MSG_MIX_SEL   = 5'h01;
    localparam logic [4:0] MSG_GAIN      = 5'h02;
    localparam logic [4:0] MSG_PAN       = 5'h03;
    localparam logic [4:0] MSG_FLAG      = 5'h04;
    localparam logic [4:0] MSG_OUT_VOL   = 5'h05;
    localparam logic [4:0] MSG_OUT_FLAG  = 5'h06;
    localparam logic [4:0] MSG_MAIN_VOL  = 5'h07;
    localparam logic [4:0] MSG_HP_VOL    = 5'h08;
    localparam logic [4:0] MSG_HP_ASSIGN = 5'h09;
    localparam logic [4:0] MSG_IGN_A     = 5'h0a;
    localparam logic [4:0] MSG_IGN_C     = 5'h0c;
    localparam logic [4:0] MSG_BOOST     = 5'h0d;
    localparam logic [4:0] MSG_NOMINAL   = 5'h0e;
    localparam logic [4:0] MSG_IN_GAIN   = 5'h15;
    localparam logic [4:0] MSG_IN_FLAG   = 5'h16;
    localparam logic [4:0] MSG_BALANCE   = 5'h17;
    localparam logic [4:0] MSG_WIDTH     = 5'h18;
    localparam logic [4:0] MSG_METER     = 5'h1f;

    localparam logic REG_METER_SEL = 1'b0;
    localparam logic REG_EVENTS    = 1'b1;

    localparam logic RES_EVENT = 1'b0;
    localparam logic RES_METER = 1'b1;

    localparam logic [7:0] NO_MIXER      = 8'hff;
    localparam logic [8:0] METER_HI_BASE = 9'h080;

endpackage

FILE: rtl/dmst_seq.sv
// ----------------------------------------------------------------------------
// dmst_seq
// Message decode and channel sequencing; forms the cache address per beat.
// ----------------------------------------------------------------------------
module dmst_seq #(
    parameter int MIXERS       = 4,
    parameter int SOURCES      = 20,
    parameter int INPUTS       = 10,
    parameter int METER_INPUTS = 24,
    parameter int METERS       = 48,
    parameter int AW           = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  dmst_pkg::t_in   i_data,
    input  logic            i_meter_sel,
    output dmst_pkg::t_req  o_req,
    output logic [AW-1:0]   o_addr
);
    import dmst_pkg::*;

    localparam int SRC_DEPTH = 5 * MIXERS * SOURCES;
    localparam int MIX_BASE  = SRC_DEPTH;
    localparam int GLB_BASE  = MIX_BASE + 2 * MIXERS;
    localparam int INP_BASE  = GLB_BASE + 5;

    localparam logic [7:0] L_MIXERS  = 8'(MIXERS);
    localparam logic [7:0] L_SOURCES = 8'(SOURCES);
    localparam logic [7:0] L_INPUTS  = 8'(INPUTS);
    localparam logic [7:0] L_MINPUTS = 8'(METER_INPUTS);
    localparam logic [8:0] L_METERS  = 9'(METERS);

    logic [7:0] r_cur_mix,  n_cur_mix;
    logic [7:0] r_cur_src,  n_cur_src;
    logic [4:0] r_last_src, n_last_src;
    logic [7:0] r_cur_in,   n_cur_in;
    logic [4:0] r_last_msg, n_last_msg;

    logic [4:0] msg;
    logic [7:0] v;
    logic [7:0] ch;
    logic [7:0] p;
    logic [8:0] slot_hi;
    logic [2:0] kind;
    logic       mix_ok;

    assign msg    = i_data.flag_byte[7:3];
    assign v      = i_data.setting_byte;
    assign mix_ok = r_cur_mix < L_MIXERS;
    assign p      = i_meter_sel ? i_data.index_byte_six : i_data.index_byte_seven;
    assign slot_hi = {1'b0, p} - METER_HI_BASE + 9'(METER_INPUTS);

    always_comb begin
        n_cur_mix  = r_cur_mix;
        n_cur_src  = r_cur_src;
        n_last_src = r_last_src;
        n_cur_in   = r_cur_in;
        n_last_msg = r_last_msg;
        o_req      = '0;
        o_req.msg  = msg;
        o_req.value = v;
        o_addr     = '0;
        ch         = '0;
        kind       = '0;
        unique case (msg)
            MSG_MIX_SEL: begin
                if ({5'b0, v[7:5]} < L_MIXERS) begin
                    n_cur_src = '0;
                    n_cur_mix = {5'b0, v[7:5]};
                end
                n_last_msg = msg;
            end
            MSG_GAIN, MSG_PAN, MSG_FLAG, MSG_BALANCE, MSG_WIDTH: begin
                unique case (msg)
                    MSG_GAIN:    kind = 3'd0;
                    MSG_PAN:     kind = 3'd1;
                    MSG_FLAG:    kind = 3'd2;
                    MSG_BALANCE: kind = 3'd3;
                    default:     kind = 3'd4;
                endcase
                ch = (msg != r_last_src) ? 8'd0 : r_cur_src + 8'd1;
                n_last_src = msg;
                if (mix_ok && ch < L_SOURCES) begin
                    n_cur_src      = ch;
                    o_req.is_cache = 1'b1;
                    o_req.first    = r_cur_mix;
                    o_req.second   = ch;
                    o_addr = (AW'(kind) * AW'(MIXERS) + AW'(r_cur_mix)) * AW'(SOURCES)
                             + AW'(ch);
                end
                n_last_msg = msg;
            end
            MSG_OUT_VOL, MSG_OUT_FLAG: begin
                if (mix_ok) begin
                    o_req.is_cache = 1'b1;
                    o_req.first    = r_cur_mix;
                    o_addr = AW'(MIX_BASE) + ((msg == MSG_OUT_FLAG) ? AW'(MIXERS) : '0)
                             + AW'(r_cur_mix);
                end
                n_last_msg = msg;
            end
            MSG_MAIN_VOL, MSG_HP_VOL, MSG_HP_ASSIGN, MSG_BOOST, MSG_NOMINAL: begin
                o_req.is_cache = 1'b1;
                unique case (msg)
                    MSG_MAIN_VOL:  o_addr = AW'(GLB_BASE);
                    MSG_HP_VOL:    o_addr = AW'(GLB_BASE + 1);
                    MSG_HP_ASSIGN: o_addr = AW'(GLB_BASE + 2);
                    MSG_BOOST:     o_addr = AW'(GLB_BASE + 3);
                    default:       o_addr = AW'(GLB_BASE + 4);
                endcase
                n_last_msg = msg;
            end
            MSG_IN_GAIN, MSG_IN_FLAG: begin
                ch = (r_last_msg != msg) ? 8'd0 : r_cur_in + 8'd1;
                if (ch < L_INPUTS) begin
                    n_cur_in       = ch;
                    o_req.is_cache = 1'b1;
                    o_req.first    = ch;
                    o_addr = AW'(INP_BASE) + ((msg == MSG_IN_FLAG) ? AW'(INPUTS) : '0)
                             + AW'(ch);
                end
                n_last_msg = msg;
            end
            MSG_IGN_A, MSG_IGN_C: begin
                n_last_msg = msg;
            end
            MSG_METER: begin
                if (p < L_MINPUTS) begin
                    o_req.is_meter = 1'b1;
                    o_req.first    = p;
                end else if (p[7] && slot_hi < L_METERS) begin
                    o_req.is_meter = 1'b1;
                    o_req.first    = slot_hi[7:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mix  <= NO_MIXER;
            r_cur_src  <= 8'hff;
            r_last_src <= '0;
            r_cur_in   <= '0;
            r_last_msg <= '0;
        end else if (i_accept) begin
            r_cur_mix  <= n_cur_mix;
            r_cur_src  <= n_cur_src;
            r_last_src <= n_last_src;
            r_cur_in   <= n_cur_in;
            r_last_msg <= n_last_msg;
        end
    end

endmodule

FILE: rtl/dsp_message_state_tracker_core.sv
// ----------------------------------------------------------------------------
// dsp_message_state_tracker_core
// Tracks DSP parameter messages and reports changes and meter levels.
// ----------------------------------------------------------------------------
// Input channel: one beat per data block (flag, value, two meter index bytes).
// Output channel: at most one result beat per input beat, either a parameter
// change event (only when events are enabled) or a meter level update.
// Sequencing state sits in flip-flops and is updated as a beat is accepted;
// all cached parameters live in one single-port-write, registered-read
// memory that is read on accept and written back as the beat leaves the
// cache stage. A write followed by a read of the same entry is forwarded.
// A result passes from the cache stage register into the result register.
// Throughput: one beat per cycle while the output is not stalled.
// Reset: a clearing pass zeroes the whole cache, one entry per cycle, over
// 5*MIXERS*SOURCES + 2*MIXERS + 5 + 2*INPUTS entries (433 at the defaults);
// o_in_stall is high throughout. Configuration writes are taken at any time.
// Stall: the result register holds a valid result while i_out_stall is high;
// a second beat may wait in the cache stage, after which o_in_stall is raised.
// ----------------------------------------------------------------------------
module dsp_message_state_tracker_core #(
    parameter int MIXERS       = 4,
    parameter int SOURCES      = 20,
    parameter int INPUTS       = 10,
    parameter int METER_INPUTS = 24,
    parameter int METERS       = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dmst_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dmst_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic            i_cfg_data
);
    import dmst_pkg::*;

    localparam int DEPTH = 5 * MIXERS * SOURCES + 2 * MIXERS + 5 + 2 * INPUTS;
    localparam int AW    = $clog2(DEPTH);

    logic r_meter_sel;
    logic r_events;

    logic          accept;
    logic          advance;
    t_req          req;
    logic [AW-1:0] req_addr;

    logic          r_s1_valid;
    t_req          r_s1_req;
    logic [AW-1:0] r_s1_addr;

    logic [7:0]    r_cache [DEPTH];
    logic [7:0]    r_rdata;
    logic          r_wr_valid;
    logic [AW-1:0] r_wr_addr;
    logic [7:0]    r_wr_data;

    logic          r_clearing;
    logic [AW-1:0] r_clr_cnt;

    logic [7:0]    old_val;
    logic          changed;
    logic          s1_write;
    logic          s1_result;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    logic          r_out_valid;
    t_out          r_out_data;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clearing || (r_s1_valid && !advance);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_sel <= 1'b0;
            r_events    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_METER_SEL: r_meter_sel <= i_cfg_data;
                REG_EVENTS:    r_events    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dmst_seq #(
        .MIXERS       (MIXERS),
        .SOURCES      (SOURCES),
        .INPUTS       (INPUTS),
        .METER_INPUTS (METER_INPUTS),
        .METERS       (METERS),
        .AW           (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_in_data),
        .i_meter_sel (r_meter_sel),
        .o_req       (req),
        .o_addr      (req_addr)
    );

    // Cache stage: compare with stored value, write back on change
    assign old_val   = (r_wr_valid && r_wr_addr == r_s1_addr) ? r_wr_data : r_rdata;
    assign changed   = old_val != r_s1_req.value;
    assign s1_write  = r_s1_valid && r_s1_req.is_cache && changed;
    assign s1_result = r_s1_req.is_meter || (r_s1_req.is_cache && changed && r_events);

    assign mem_we    = r_clearing || (s1_write && advance);
    assign mem_waddr = r_clearing ? r_clr_cnt : r_s1_addr;
    assign mem_wdata = r_clearing ? 8'd0 : r_s1_req.value;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cache[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rdata <= r_cache[req_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_wr_valid <= s1_write;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req  <= req;
            r_s1_addr <= req_addr;
        end
        if (advance) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= r_s1_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && s1_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data.result_kind  <= r_s1_req.is_meter ? RES_METER : RES_EVENT;
            r_out_data.message_kind <= r_s1_req.msg;
            r_out_data.first_index  <= r_s1_req.first;
            r_out_data.second_index <= r_s1_req.second;
            r_out_data.new_setting  <= r_s1_req.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: tb/dmst_tracker_checker.sv
// ----------------------------------------------------------------------------
// dmst_tracker_checker
// Watches both channels and the register port of the DSP message state
// tracker. It keeps its own copy of the parameter caches and channel
// sequencing, works out the result each accepted input beat should give, and
// compares every accepted output beat field by field with the oldest
// prediction. Mismatches and unexpected beats are counted.
// ----------------------------------------------------------------------------
module dmst_tracker_checker #(
    parameter int MIXERS       = 4,
    parameter int SOURCES      = 20,
    parameter int INPUTS       = 10,
    parameter int METER_INPUTS = 24,
    parameter int METERS       = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  dmst_pkg::t_in   i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  dmst_pkg::t_out  i_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic            i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    import dmst_pkg::*;

    logic [7:0] src_cache [5][MIXERS][SOURCES];
    logic [7:0] out_cache [2][MIXERS];
    logic [7:0] glob_cache [5];
    logic [7:0] in_cache [2][INPUTS];
    logic [7:0] cur_mixer;
    logic [7:0] cur_source;
    logic [7:0] cur_input;
    logic [4:0] last_src_type;
    logic [4:0] last_msg;
    logic       meter_sel;
    logic       events_on;

    t_out pending_results [$];
    int   mismatches = 0;

    task automatic post_event(input logic [7:0] old, input logic [7:0] v,
                              input logic [4:0] msg, input logic [7:0] first,
                              input logic [7:0] second);
        if (old != v && events_on) begin
            pending_results.push_back(t_out'{RES_EVENT, msg, first, second, v});
        end
    endtask

    task automatic track_message(input t_in beat);
        logic [4:0] msg;
        logic [7:0] v;
        logic [7:0] ch;
        logic [7:0] old;
        logic [7:0] p;
        int         kind;
        int         gi;
        int         slot;
        bit         seq_msg;
        msg     = beat.flag_byte[7:3];
        v       = beat.setting_byte;
        seq_msg = 1'b1;
        case (msg)
            MSG_MIX_SEL: begin
                if (int'(v[7:5]) < MIXERS) begin
                    cur_source = 8'd0;
                    cur_mixer  = {5'd0, v[7:5]};
                end
            end
            MSG_GAIN, MSG_PAN, MSG_FLAG, MSG_BALANCE, MSG_WIDTH: begin
                case (msg)
                    MSG_GAIN:    kind = 0;
                    MSG_PAN:     kind = 1;
                    MSG_FLAG:    kind = 2;
                    MSG_BALANCE: kind = 3;
                    default:     kind = 4;
                endcase
                ch = (msg != last_src_type) ? 8'd0 : cur_source + 8'd1;
                last_src_type = msg;
                if (int'(cur_mixer) < MIXERS && int'(ch) < SOURCES) begin
                    old = src_cache[kind][cur_mixer][ch];
                    src_cache[kind][cur_mixer][ch] = v;
                    post_event(old, v, msg, cur_mixer, ch);
                    cur_source = ch;
                end
            end
            MSG_OUT_VOL, MSG_OUT_FLAG: begin
                if (int'(cur_mixer) < MIXERS) begin
                    kind = (msg == MSG_OUT_FLAG) ? 1 : 0;
                    old  = out_cache[kind][cur_mixer];
                    out_cache[kind][cur_mixer] = v;
                    post_event(old, v, msg, cur_mixer, 8'd0);
                end
            end
            MSG_MAIN_VOL, MSG_HP_VOL, MSG_HP_ASSIGN, MSG_BOOST, MSG_NOMINAL: begin
                case (msg)
                    MSG_MAIN_VOL:  gi = 0;
                    MSG_HP_VOL:    gi = 1;
                    MSG_HP_ASSIGN: gi = 2;
                    MSG_BOOST:     gi = 3;
                    default:       gi = 4;
                endcase
                old = glob_cache[gi];
                glob_cache[gi] = v;
                post_event(old, v, msg, 8'd0, 8'd0);
            end
            MSG_IN_GAIN, MSG_IN_FLAG: begin
                ch = (last_msg != msg) ? 8'd0 : cur_input + 8'd1;
                if (int'(ch) < INPUTS) begin
                    kind = (msg == MSG_IN_FLAG) ? 1 : 0;
                    old  = in_cache[kind][ch];
                    in_cache[kind][ch] = v;
                    post_event(old, v, msg, ch, 8'd0);
                    cur_input = ch;
                end
            end
            MSG_IGN_A, MSG_IGN_C: begin
            end
            MSG_METER: begin
                // meters leave the sequencing alone
                seq_msg = 1'b0;
                p = meter_sel ? beat.index_byte_six : beat.index_byte_seven;
                if (int'(p) < METER_INPUTS) begin
                    pending_results.push_back(t_out'{RES_METER, msg, p, 8'd0, v});
                end else if (int'(p) >= int'(METER_HI_BASE)) begin
                    slot = int'(p) - int'(METER_HI_BASE) + METER_INPUTS;
                    if (slot < METERS) begin
                        pending_results.push_back(
                            t_out'{RES_METER, msg, 8'(slot), 8'd0, v});
                    end
                end
            end
            default: begin
                seq_msg = 1'b0;
            end
        endcase
        if (seq_msg) begin
            last_msg = msg;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                for (int m = 0; m < MIXERS; m++) begin
                    for (int s = 0; s < SOURCES; s++) begin
                        src_cache[k][m][s] = 8'd0;
                    end
                end
                glob_cache[k] = 8'd0;
            end
            for (int k = 0; k < 2; k++) begin
                for (int m = 0; m < MIXERS; m++) begin
                    out_cache[k][m] = 8'd0;
                end
                for (int c = 0; c < INPUTS; c++) begin
                    in_cache[k][c] = 8'd0;
                end
            end
            cur_mixer     = NO_MIXER;
            cur_source    = 8'hff;
            cur_input     = 8'd0;
            last_src_type = 5'd0;
            last_msg      = 5'd0;
            meter_sel     = 1'b0;
            events_on     = 1'b0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: kind %0d msg %h idx %h %h value %h",
                                 got.result_kind, got.message_kind, got.first_index,
                                 got.second_index, got.new_setting);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.result_kind !== want.result_kind
                            || got.message_kind !== want.message_kind
                            || got.first_index !== want.first_index
                            || got.second_index !== want.second_index
                            || got.new_setting !== want.new_setting) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected kind %0d msg %h idx %h %h value %h",
                                     want.result_kind, want.message_kind, want.first_index,
                                     want.second_index, want.new_setting);
                            $display("          actual   kind %0d msg %h idx %h %h value %h",
                                     got.result_kind, got.message_kind, got.first_index,
                                     got.second_index, got.new_setting);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_METER_SEL) begin
                    meter_sel = i_cfg_data;
                end else begin
                    events_on = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                track_message(i_in_data);
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the DSP message state tracker with a directed set of messages and
// then phases of random message runs under each register setting, with
// random idle bursts on both channels in all but the last phase. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import dmst_pkg::*;

    localparam int MIXERS       = 4;
    localparam int SOURCES      = 20;
    localparam int INPUTS       = 10;
    localparam int METER_INPUTS = 24;
    localparam int METERS       = 48;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_BEATS  = 80;
    localparam logic [4:0] MSG_UNKNOWN = 5'h0b;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    logic cfg_we;
    logic cfg_idx;
    logic cfg_data;
    int   fail_count;
    int   pending;
    bit   idle_on;
    int   stall_left  = 0;
    int   idle_cycles = 0;

    logic [4:0] src_types [5] = '{MSG_GAIN, MSG_PAN, MSG_FLAG, MSG_BALANCE, MSG_WIDTH};
    logic [4:0] plain_types [9] = '{MSG_OUT_VOL, MSG_OUT_FLAG, MSG_MAIN_VOL, MSG_HP_VOL,
                                    MSG_HP_ASSIGN, MSG_BOOST, MSG_NOMINAL, MSG_IGN_A,
                                    MSG_IGN_C};

    dsp_message_state_tracker_core #(
        .MIXERS       (MIXERS),
        .SOURCES      (SOURCES),
        .INPUTS       (INPUTS),
        .METER_INPUTS (METER_INPUTS),
        .METERS       (METERS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    dmst_tracker_checker #(
        .MIXERS       (MIXERS),
        .SOURCES      (SOURCES),
        .INPUTS       (INPUTS),
        .METER_INPUTS (METER_INPUTS),
        .METERS       (METERS)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver side: random stall bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
        end
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_setting();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, METER_INPUTS));
            1:       return 8'($urandom_range(int'(METER_HI_BASE),
                                              int'(METER_HI_BASE) + METERS - METER_INPUTS));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] mixer_setting();
        if ($urandom_range(0, 4) == 0) begin
            return 8'($urandom);
        end
        return {3'($urandom_range(0, MIXERS)), 5'($urandom)};
    endfunction

    // one input beat, with an optional idle burst ahead of it
    task automatic send(input logic [4:0] kind, input logic [7:0] value,
                        input logic [7:0] six, input logic [7:0] seven);
        t_in beat;
        beat.flag_byte        = {kind, 3'($urandom)};
        beat.setting_byte     = value;
        beat.index_byte_six   = six;
        beat.index_byte_seven = seven;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
    endtask

    task automatic wait_quiet();
        int quiet;
        quiet = 0;
        in_valid <= 1'b0;
        while (quiet < 5) begin
            @(posedge clk);
            if (pending == 0 && out_valid !== 1'b1) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic value);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int         n;
        int         len;
        int         pick;
        logic [4:0] kind;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                if (pick <= 3) begin
                    kind = src_types[$urandom_range(0, 4)];
                    len  = $urandom_range(1, SOURCES + 4);
                    if ($urandom_range(0, 1) == 1) begin
                        send(MSG_MIX_SEL, mixer_setting(), pick_index(), pick_index());
                        n++;
                    end
                end else begin
                    kind = ($urandom_range(0, 1) == 1) ? MSG_IN_FLAG : MSG_IN_GAIN;
                    len  = $urandom_range(1, INPUTS + 3);
                end
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send(5'($urandom), pick_setting(), pick_index(), pick_index());
                        n++;
                    end
                    send(kind, pick_setting(), pick_index(), pick_index());
                    n++;
                end
            end else begin
                case (pick)
                    6:       send(MSG_MIX_SEL, mixer_setting(), pick_index(), pick_index());
                    7:       send(plain_types[$urandom_range(0, 8)], pick_setting(),
                                  pick_index(), pick_index());
                    8:       send(MSG_METER, pick_setting(), pick_index(), pick_index());
                    default: send(5'($urandom), pick_setting(), pick_index(), pick_index());
                endcase
                n++;
            end
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_METER_SEL;
        cfg_data = 1'b0;
        idle_on  = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_METER_SEL, 1'b0);
        write_reg(REG_EVENTS, 1'b1);

        // no mixer yet, then out of range and valid selects
        send(MSG_GAIN, 8'h05, pick_index(), pick_index());
        send(MSG_OUT_VOL, 8'h09, pick_index(), pick_index());
        send(MSG_MIX_SEL, 8'h80, pick_index(), pick_index());
        send(MSG_MIX_SEL, 8'h60, pick_index(), pick_index());
        send(MSG_GAIN, 8'hff, pick_index(), pick_index());
        send(MSG_PAN, 8'h00, pick_index(), pick_index());
        send(MSG_FLAG, 8'h80, pick_index(), pick_index());
        send(MSG_BALANCE, 8'h01, pick_index(), pick_index());
        send(MSG_WIDTH, 8'h7f, pick_index(), pick_index());
        send(MSG_OUT_VOL, 8'hff, pick_index(), pick_index());
        send(MSG_OUT_FLAG, 8'h01, pick_index(), pick_index());
        send(MSG_MAIN_VOL, 8'h40, pick_index(), pick_index());
        send(MSG_HP_VOL, 8'h20, pick_index(), pick_index());
        send(MSG_HP_ASSIGN, 8'h03, pick_index(), pick_index());
        send(MSG_BOOST, 8'h01, pick_index(), pick_index());
        send(MSG_NOMINAL, 8'hff, pick_index(), pick_index());
        send(MSG_IGN_A, 8'h11, pick_index(), pick_index());
        send(MSG_IGN_C, 8'h22, pick_index(), pick_index());
        // unknown type inside an input run must not break it
        send(MSG_IN_GAIN, 8'h10, pick_index(), pick_index());
        send(MSG_UNKNOWN, 8'h33, pick_index(), pick_index());
        send(MSG_IN_GAIN, 8'h20, pick_index(), pick_index());
        send(MSG_IN_FLAG, 8'h01, pick_index(), pick_index());
        // meter slot edges
        send(MSG_METER, 8'h00, pick_index(), 8'h00);
        send(MSG_METER, 8'hff, pick_index(), 8'(METER_INPUTS));
        send(MSG_METER, 8'h55, pick_index(), 8'(int'(METER_HI_BASE)));
        send(MSG_METER, 8'haa, pick_index(),
             8'(int'(METER_HI_BASE) + METERS - METER_INPUTS - 1));
        send(MSG_METER, 8'h01, pick_index(),
             8'(int'(METER_HI_BASE) + METERS - METER_INPUTS));

        write_reg(REG_METER_SEL, 1'b1);
        random_phase(PHASE_BEATS);
        write_reg(REG_METER_SEL, 1'b0);
        write_reg(REG_EVENTS, 1'b0);
        random_phase(PHASE_BEATS);
        write_reg(REG_METER_SEL, 1'b1);
        random_phase(PHASE_BEATS);
        write_reg(REG_METER_SEL, 1'b0);
        write_reg(REG_EVENTS, 1'b1);
        random_phase(PHASE_BEATS);
        write_reg(REG_METER_SEL, 1'b1);
        idle_on <= 1'b0;
        random_phase(PHASE_BEATS);

        wait_quiet();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
